// ===== design/color_key_sprite_blitter_macros.svh =====
// assertion macros for the color-key sprite blitter checker
// expects signals named clock and reset in the scope where a macro is used
`ifndef COLOR_KEY_SPRITE_BLITTER_MACROS_SVH
`define COLOR_KEY_SPRITE_BLITTER_MACROS_SVH

// property checked at every edge, also while reset is high
`define CKB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// property checked only outside reset
`define CKB_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== design/ckb_pkg.sv =====
// shared types and constants for the color-key sprite blitter
// no dependencies; imported by every module of the block
`default_nettype none

package ckb_pkg;

   // screen defaults
   localparam int CKB_SCREEN_W = 320;
   localparam int CKB_SCREEN_H = 200;

   // field and register widths
   localparam int ORIGIN_W   = 11;
   localparam int SIZE_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int ADDR_W     = 16;
   localparam int COORD_W    = 10;  // screen coordinate, screen is at most 1024 wide and high
   localparam int POS_W      = 12;  // signed origin plus sprite counter
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // queue between front and back, power of two
   localparam int QUEUE_DEPTH = 2;

   // transparent color key
   localparam logic [COLOR_W-1:0] TRANSPARENT_KEY = '0;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ORIGIN_X      = 2'd0,
      CSR_ORIGIN_Y      = 2'd1,
      CSR_SPRITE_WIDTH  = 2'd2,
      CSR_SPRITE_HEIGHT = 2'd3
   } csr_index_type;

   // one classified pixel, front to back
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               on_screen;
      logic               last;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } pixel_item_type;

endpackage

`default_nettype wire

// ===== design/ckb_front.sv =====
// front end: config registers, sprite counters, clipping and last-pixel tagging
// depends on ckb_pkg; feeds ckb_fifo
`default_nettype none

module ckb_front
   import ckb_pkg::*;
#(
   parameter int SCREEN_W = CKB_SCREEN_W,
   parameter int SCREEN_H = CKB_SCREEN_H
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] sprite_color
   input  wire logic                  queue_full,
   output logic                       push,
   output pixel_item_type             push_item
);

   localparam logic signed [POS_W-1:0] SCREEN_W_POS = POS_W'(SCREEN_W);
   localparam logic signed [POS_W-1:0] SCREEN_H_POS = POS_W'(SCREEN_H);

   logic [ORIGIN_W-1:0] origin_x_ff, origin_x_in;
   logic [ORIGIN_W-1:0] origin_y_ff, origin_y_in;
   logic [SIZE_W-1:0]   sprite_width_ff, sprite_width_in;
   logic [SIZE_W-1:0]   sprite_height_ff, sprite_height_in;
   logic [SIZE_W-1:0]   column_count_ff, column_count_in;
   logic [SIZE_W-1:0]   row_count_ff, row_count_in;

   logic signed [POS_W-1:0] screen_x;
   logic signed [POS_W-1:0] screen_y;
   logic                    on_screen;
   logic [SIZE_W:0]         width_extent;
   logic [SIZE_W:0]         height_extent;
   logic [SIZE_W:0]         column_next;
   logic [SIZE_W:0]         row_next;
   logic                    row_end;
   logic                    last;

   // accept whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // register writes
   always_comb begin
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      sprite_width_in  = sprite_width_ff;
      sprite_height_in = sprite_height_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ORIGIN_X:      origin_x_in      = csr_wdata[ORIGIN_W-1:0];
            CSR_ORIGIN_Y:      origin_y_in      = csr_wdata[ORIGIN_W-1:0];
            CSR_SPRITE_WIDTH:  sprite_width_in  = csr_wdata[SIZE_W-1:0];
            CSR_SPRITE_HEIGHT: sprite_height_in = csr_wdata[SIZE_W-1:0];
         endcase
      end
   end

   // screen position of the current pixel
   assign screen_x = $signed({{(POS_W-ORIGIN_W){origin_x_ff[ORIGIN_W-1]}}, origin_x_ff})
                   + $signed({{(POS_W-SIZE_W){1'b0}}, column_count_ff});
   assign screen_y = $signed({{(POS_W-ORIGIN_W){origin_y_ff[ORIGIN_W-1]}}, origin_y_ff})
                   + $signed({{(POS_W-SIZE_W){1'b0}}, row_count_ff});

   assign on_screen = !screen_x[POS_W-1] && (screen_x < SCREEN_W_POS)
                   && !screen_y[POS_W-1] && (screen_y < SCREEN_H_POS);

   // a size of zero stands for 256
   assign width_extent  = (sprite_width_ff == '0) ? {1'b1, {SIZE_W{1'b0}}}
                                                  : {1'b0, sprite_width_ff};
   assign height_extent = (sprite_height_ff == '0) ? {1'b1, {SIZE_W{1'b0}}}
                                                   : {1'b0, sprite_height_ff};
   assign column_next = {1'b0, column_count_ff} + (SIZE_W+1)'(1);
   assign row_next    = {1'b0, row_count_ff} + (SIZE_W+1)'(1);
   assign row_end     = column_next >= width_extent;
   assign last        = row_end && (row_next >= height_extent);

   // counter stepping per accepted word
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (push) begin
         priority if (last) begin
            column_count_in = '0;
            row_count_in    = '0;
         end else if (row_end) begin
            column_count_in = '0;
            row_count_in    = row_next[SIZE_W-1:0];
         end else begin
            column_count_in = column_next[SIZE_W-1:0];
         end
      end
   end

   // classified pixel for the queue
   always_comb begin
      push_item.color     = req_tdata[COLOR_W-1:0];
      push_item.on_screen = on_screen;
      push_item.last      = last;
      push_item.col       = screen_x[COORD_W-1:0];
      push_item.row       = screen_y[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         sprite_width_ff  <= SIZE_W'(1);
         sprite_height_ff <= SIZE_W'(1);
         column_count_ff  <= '0;
         row_count_ff     <= '0;
      end else begin
         origin_x_ff      <= origin_x_in;
         origin_y_ff      <= origin_y_in;
         sprite_width_ff  <= sprite_width_in;
         sprite_height_ff <= sprite_height_in;
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/ckb_fifo.sv =====
// short queue of classified pixels between front and back
// depends on ckb_pkg; depth is a power of two, at least two
`default_nettype none

module ckb_fifo
   import ckb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire pixel_item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output pixel_item_type pop_item,
   output logic          not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pixel_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/ckb_back.sv =====
// back end: frame-buffer address multiply, write enable and output register
// depends on ckb_pkg; drains ckb_fifo
`default_nettype none

module ckb_back
   import ckb_pkg::*;
#(
   parameter int SCREEN_W = CKB_SCREEN_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pixel_item_type        pop_item,
   input  wire logic                  item_valid,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [15:0] pixel_address, [23:16] write_color
   output logic                       rsp_tuser,  // [0] write_enable
   output logic                       rsp_tlast   // last_pixel
);

   localparam int MUL_W = COORD_W + $clog2(SCREEN_W + 1) + 1;

   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [ADDR_W-1:0]   address_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic                write_enable_ff;
   logic                last_ff;
   logic [MUL_W-1:0]    address_full;

   // output register takes a new word when empty or being drained
   assign pop = item_valid && (!rsp_tvalid_ff || rsp_tready);

   // row times screen width plus column
   assign address_full = MUL_W'(pop_item.row) * MUL_W'(SCREEN_W) + MUL_W'(pop_item.col);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (pop) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         address_ff      <= pop_item.on_screen ? address_full[ADDR_W-1:0] : '0;
         color_ff        <= pop_item.color;
         write_enable_ff <= pop_item.on_screen && (pop_item.color != TRANSPARENT_KEY);
         last_ff         <= pop_item.last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {color_ff, address_ff};
   assign rsp_tuser  = write_enable_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== design/color_key_sprite_blitter.sv =====
// top level of the color-key sprite blitter
// depends on ckb_pkg, ckb_front, ckb_fifo and ckb_back
//
// Usage:
//   req_* carries one sprite color byte per word, row-major over the sprite.
//   rsp_* returns one frame-buffer write per word: address and color in
//   rsp_tdata, write enable in rsp_tuser, end of sprite in rsp_tlast.
//   csr_* writes origin_x, origin_y, sprite_width, sprite_height (index 0..3)
//   and must only be written while no word is in flight; the block does not enforce this.
// Timing:
//   one word per cycle sustained in both directions while rsp_tready stays high.
//   an accepted word is written into the queue, then popped into the output
//   register, which drives rsp_tvalid and the rsp_* payload. the address
//   multiply sits between the queue head and the output register.
// Reset:
//   clears the sprite counters, origin to zero and size to one pixel, and
//   empties the queue and the output register.
// Stall:
//   while rsp_tready is low the output register holds; up to two more words
//   gather in the queue, then req_tready drops until the receiver drains.
`default_nettype none

module color_key_sprite_blitter
   import ckb_pkg::*;
#(
   parameter int SCREEN_W = CKB_SCREEN_W,
   parameter int SCREEN_H = CKB_SCREEN_H
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] sprite_color
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [15:0] pixel_address, [23:16] write_color
   output logic                       rsp_tuser,  // [0] write_enable
   output logic                       rsp_tlast   // last_pixel
);

   pixel_item_type push_item;
   pixel_item_type pop_item;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_not_empty;

   // counters and classification
   ckb_front #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // decoupling queue
   ckb_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (queue_not_empty)
   );

   // address and output register
   ckb_back #(
      .SCREEN_W (SCREEN_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_item   (pop_item),
      .item_valid (queue_not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== design/ckb_checker.sv =====
// port-level assertions for the color-key sprite blitter, bound to the top level
// depends on ckb_pkg and color_key_sprite_blitter_macros.svh
`default_nettype none
`include "color_key_sprite_blitter_macros.svh"

module ckb_checker
   import ckb_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   // reset empties the output register and the queue
   `CKB_ASSERT(a_reset_clears_out, reset |=> !rsp_tvalid, "output valid after reset")
   `CKB_ASSERT(a_reset_frees_in, reset |=> req_tready, "input not ready after reset")

   // a stalled word stays offered
   `CKB_ASSERT_RUN(a_hold_valid, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")

   // a write is never issued for the transparent key
   `CKB_ASSERT_RUN(a_no_key_write, rsp_tvalid && rsp_tuser |-> rsp_tdata[23:16] != '0, "key written")

endmodule

bind color_key_sprite_blitter ckb_checker u_ckb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
